// ===== hdl/pft_pkg.sv =====
// ----------------------------------------------------------------------------
// pft_pkg: shared types and constants for the page fault frequency tracker
// Holds default sizes, fixed field widths and the controller command bundle.
// ----------------------------------------------------------------------------
package pft_pkg;

    // default table geometry
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int PAGE_BITS_DEF   = 20;

    // fixed field widths
    localparam int WINDOW_W = 16;
    localparam int COUNT_W  = 7;
    localparam int TIME_W   = 32;

    // fault window after reset
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture the incoming request
        logic lookup;  // compare tags, decide on a sweep
        logic commit;  // update the table and load the result register
    } pft_cmd_t;

endpackage

// ===== hdl/pft_ctrl.sv =====
// ----------------------------------------------------------------------------
// pft_ctrl: request sequencer for the page fault frequency tracker
// Steps each request through lookup and update, owns the handshakes and
// the result valid flag.
// ----------------------------------------------------------------------------
module pft_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output pft_pkg::pft_cmd_t cmd
);
    import pft_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   commit;
    logic   accept;

    // update may finish once the result register is free or draining
    assign commit   = (state_reg == S_UPDATE) && (!out_valid_reg || !out_stall);
    assign in_stall = !((state_reg == S_IDLE) || commit);
    assign accept   = in_valid && !in_stall;

    assign cmd.load   = accept;
    assign cmd.lookup = (state_reg == S_LOOKUP);
    assign cmd.commit = commit;
    assign out_valid  = out_valid_reg;

    // next state and result flag
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = accept ? S_LOOKUP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // an accepted request is looked up in the next cycle
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_LOOKUP))
        else $error("accepted request did not enter lookup");

    // lookup is always followed by update
    a_lookup_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOKUP) |=> (state_reg == S_UPDATE))
        else $error("lookup not followed by update");

    // a finished update always presents a result
    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("result lost after update");

endmodule

// ===== hdl/pft_dp.sv =====
// ----------------------------------------------------------------------------
// pft_dp: resident page table datapath
// Tag compare, sweep decision, sweep and insert, reference timing and
// the result register.
// ----------------------------------------------------------------------------
module pft_dp
#(
    parameter int TABLE_DEPTH = pft_pkg::TABLE_DEPTH_DEF,
    parameter int PAGE_BITS   = pft_pkg::PAGE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pft_pkg::pft_cmd_t             cmd,
    input  logic                          cfg_wr_en,
    input  logic [pft_pkg::WINDOW_W-1:0]  cfg_wr_data,
    input  logic [PAGE_BITS-1:0]          page_number,
    output logic                          hit,
    output logic                          swept,
    output logic [pft_pkg::COUNT_W-1:0]   evicted_count,
    output logic [pft_pkg::COUNT_W-1:0]   resident_count,
    output logic                          overflow
);
    import pft_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // table
    logic [PAGE_BITS-1:0]   tag_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] use_reg, use_next;
    logic [CNT_W-1:0]       resident_reg, resident_next;
    logic [CNT_W-1:0]       unused_reg, unused_next;

    // request and lookup results
    logic [PAGE_BITS-1:0]   page_reg;
    logic [TABLE_DEPTH-1:0] match_reg, match_vec;
    logic                   hit_reg;
    logic                   sweep_reg;
    logic                   sweep_due;

    // timing and configuration
    logic [TIME_W-1:0]      ref_count_reg;
    logic [TIME_W-1:0]      last_fault_reg;
    logic [WINDOW_W-1:0]    window_reg;

    // update path
    logic [TABLE_DEPTH-1:0] valid_sw, use_sw, free_vec, ins_onehot;
    logic [CNT_W-1:0]       resident_sw, unused_sw, evicted;
    logic                   any_free;

    // result register
    logic                   hit_out_reg, swept_out_reg, overflow_out_reg;
    logic [COUNT_W-1:0]     evicted_out_reg, resident_out_reg;

    // parallel tag compare against valid entries
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match_vec[i] = valid_reg[i] && (tag_reg[i] == page_reg);
        end
    end

    // references since last fault against the window, modulo 2^32
    assign sweep_due = ((ref_count_reg - last_fault_reg) >= TIME_W'(window_reg));

    // sweep view of the table, then first free entry
    always_comb
    begin
        if (sweep_reg)
        begin
            valid_sw    = valid_reg & use_reg;
            use_sw      = '0;
            evicted     = unused_reg;
            resident_sw = resident_reg - unused_reg;
            unused_sw   = resident_reg - unused_reg;
        end
        else
        begin
            valid_sw    = valid_reg;
            use_sw      = use_reg;
            evicted     = '0;
            resident_sw = resident_reg;
            unused_sw   = unused_reg;
        end
        free_vec   = ~valid_sw;
        ins_onehot = free_vec & (~free_vec + TABLE_DEPTH'(1));
        any_free   = |free_vec;
    end

    // next table state on commit
    always_comb
    begin
        valid_next    = valid_reg;
        use_next      = use_reg;
        resident_next = resident_reg;
        unused_next   = unused_reg;
        if (hit_reg)
        begin
            use_next = use_reg | match_reg;
            if (|(match_reg & ~use_reg))
            begin
                unused_next = unused_reg - CNT_W'(1);
            end
        end
        else
        begin
            valid_next    = valid_sw | ins_onehot;
            use_next      = use_sw | ins_onehot;
            resident_next = any_free ? (resident_sw + CNT_W'(1)) : resident_sw;
            unused_next   = unused_sw;
        end
    end

    // control and bookkeeping registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            use_reg        <= '0;
            resident_reg   <= '0;
            unused_reg     <= '0;
            ref_count_reg  <= '0;
            last_fault_reg <= '0;
            window_reg     <= WINDOW_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                valid_reg     <= valid_next;
                use_reg       <= use_next;
                resident_reg  <= resident_next;
                unused_reg    <= unused_next;
                ref_count_reg <= ref_count_reg + TIME_W'(1);
                if (!hit_reg)
                begin
                    last_fault_reg <= ref_count_reg;
                end
            end
        end
    end

    // request capture, lookup results and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= page_number;
        end
        if (cmd.lookup)
        begin
            match_reg <= match_vec;
            hit_reg   <= |match_vec;
            sweep_reg <= !(|match_vec) && sweep_due;
        end
        if (cmd.commit)
        begin
            hit_out_reg      <= hit_reg;
            swept_out_reg    <= sweep_reg;
            overflow_out_reg <= !hit_reg && !any_free;
            evicted_out_reg  <= COUNT_W'(evicted);
            resident_out_reg <= COUNT_W'(resident_next);
        end
    end

    // tag write into the inserted entry
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (cmd.commit && !hit_reg && ins_onehot[i])
            begin
                tag_reg[i] <= page_reg;
            end
        end
    end

    assign hit            = hit_out_reg;
    assign swept          = swept_out_reg;
    assign overflow       = overflow_out_reg;
    assign evicted_count  = evicted_out_reg;
    assign resident_count = resident_out_reg;

    // use bits only on resident entries
    a_use_in_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (use_reg & ~valid_reg) == '0)
        else $error("use bit set on an empty entry");

    // running resident count tracks the valid bits
    a_resident_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        resident_reg == CNT_W'($countones(valid_reg)))
        else $error("resident count out of step");

    // running unused count tracks valid entries with a clear use bit
    a_unused_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        unused_reg == CNT_W'($countones(valid_reg & ~use_reg)))
        else $error("unused count out of step");

endmodule

// ===== hdl/page_fault_frequency_tracker.sv =====
// ----------------------------------------------------------------------------
// page_fault_frequency_tracker: PFF resident set tracker
// One page reference in, one hit/sweep/residency result out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with page_number. Each accepted
//   request is one page reference and produces exactly one result.
//   Output channel: out_valid / out_stall with hit, swept, evicted_count,
//   resident_count and overflow, held stable while stalled.
//   Config: cfg_wr_en / cfg_wr_data write the 16-bit fault window; write
//   only while no request is in flight.
//   Steps: each accepted request is tag compared, then swept/inserted, and
//   its result is registered as the update completes.
//   Overlap: the compare and update steps run over the register table; a
//   new request is taken as the update of the previous one completes.
//   Stall: while a result waits on out_stall, the next request may still
//   be accepted and compared; its update holds until the result drains.
//   Reset: table empty, counters zero, fault window 2; ready at once.
// ----------------------------------------------------------------------------
module page_fault_frequency_tracker
#(
    parameter int TABLE_DEPTH = pft_pkg::TABLE_DEPTH_DEF,
    parameter int PAGE_BITS   = pft_pkg::PAGE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pft_pkg::WINDOW_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [PAGE_BITS-1:0]          page_number,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic                          swept,
    output logic [pft_pkg::COUNT_W-1:0]   evicted_count,
    output logic [pft_pkg::COUNT_W-1:0]   resident_count,
    output logic                          overflow
);
    import pft_pkg::*;

    pft_cmd_t cmd;

    // sequencer
    pft_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // table and result datapath
    pft_dp
    #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PAGE_BITS   (PAGE_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .page_number    (page_number),
        .hit            (hit),
        .swept          (swept),
        .evicted_count  (evicted_count),
        .resident_count (resident_count),
        .overflow       (overflow)
    );

endmodule

// ===== bench/pft_checker.sv =====
// ----------------------------------------------------------------------------
// pft_checker: result checker for the page fault frequency tracker
// Watches the request and result channels and the window register, keeps its own copy
// of the resident table, predicts each result and compares field by field.
// ----------------------------------------------------------------------------
module pft_checker
#(
    parameter int TABLE_DEPTH = pft_pkg::TABLE_DEPTH_DEF,
    parameter int PAGE_BITS   = pft_pkg::PAGE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pft_pkg::WINDOW_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [PAGE_BITS-1:0]          page_number,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          hit,
    input  logic                          swept,
    input  logic [pft_pkg::COUNT_W-1:0]   evicted_count,
    input  logic [pft_pkg::COUNT_W-1:0]   resident_count,
    input  logic                          overflow,
    output int                            outstanding,
    output int                            fail_count
);
    import pft_pkg::*;

    typedef struct packed {
        logic               hit;
        logic               swept;
        logic [COUNT_W-1:0] evicted;
        logic [COUNT_W-1:0] resident;
        logic               overflow;
    } ref_outcome_t;

    // shadow copy of the resident table
    logic [PAGE_BITS-1:0]   tag_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] live;
    logic [TABLE_DEPTH-1:0] used;
    logic [TIME_W-1:0]      ref_count;
    logic [TIME_W-1:0]      fault_time;
    logic [WINDOW_W-1:0]    window;

    // predicted results, oldest first
    ref_outcome_t           outcome_q [$];

    initial fail_count = 0;

    // apply one page reference to the shadow table, return its result
    function automatic ref_outcome_t track_reference(input logic [PAGE_BITS-1:0] pg);
        ref_outcome_t      res;
        int                slot;
        int                gone;
        int                n;
        int                i;
        logic [TIME_W-1:0] since;
        res  = '0;
        slot = -1;
        gone = 0;
        n    = 0;
        for (i = 0; i < TABLE_DEPTH; i++)
            if (slot < 0 && live[i] && tag_mem[i] == pg)
                slot = i;
        if (slot >= 0)
        begin
            res.hit    = 1'b1;
            used[slot] = 1'b1;
        end
        else
        begin
            // distance wraps modulo 2^32
            since = ref_count - fault_time;
            if (since >= TIME_W'(window))
            begin
                res.swept = 1'b1;
                for (i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (live[i])
                    begin
                        if (!used[i])
                        begin
                            live[i] = 1'b0;
                            gone++;
                        end
                        else
                            used[i] = 1'b0;
                    end
                end
            end
            // lowest free entry takes the page
            for (i = 0; i < TABLE_DEPTH; i++)
                if (slot < 0 && !live[i])
                    slot = i;
            if (slot >= 0)
            begin
                live[slot]    = 1'b1;
                used[slot]    = 1'b1;
                tag_mem[slot] = pg;
            end
            else
                res.overflow = 1'b1;
            fault_time = ref_count;
        end
        ref_count = ref_count + 1'b1;
        for (i = 0; i < TABLE_DEPTH; i++)
            if (live[i])
                n++;
        res.evicted  = COUNT_W'(gone);
        res.resident = COUNT_W'(n);
        return res;
    endfunction

    function automatic void compare_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endfunction

    // sample both channels at each edge: results first, then new requests
    always @(posedge clk or negedge rst_n)
    begin
        ref_outcome_t want;
        if (!rst_n)
        begin
            live       = '0;
            used       = '0;
            ref_count  = '0;
            fault_time = '0;
            window     = WINDOW_RESET;
            outcome_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                window = cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    // hit, swept, evicted, resident, overflow
                    $display("%0t: stray result, expected none, actual %0d %0d %0d %0d %0d",
                             $time, hit, swept, evicted_count, resident_count, overflow);
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    compare_field("hit", want.hit, hit);
                    compare_field("swept", want.swept, swept);
                    compare_field("evicted_count", want.evicted, evicted_count);
                    compare_field("resident_count", want.resident, resident_count);
                    compare_field("overflow", want.overflow, overflow);
                end
            end
            if (in_valid && !in_stall)
                outcome_q.push_back(track_reference(page_number));
            outstanding <= outcome_q.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the page fault frequency tracker
// Drives page references in random bursts across several fault windows,
// including zero and the maximum, with a randomly stalling receiver and one
// long hold-off. Checking is done by pft_checker alongside the block.
// ----------------------------------------------------------------------------
module tb;
    import pft_pkg::*;

    localparam int PW          = PAGE_BITS_DEF;
    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int PHASE_ITEMS = 205;
    localparam int NUM_PHASES  = 7;
    localparam int HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT = 400000;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [WINDOW_W-1:0] cfg_wr_data = '0;
    logic                in_valid    = 1'b0;
    logic [PW-1:0]       page_number = '0;
    logic                out_stall   = 1'b0;
    logic                in_stall;
    logic                out_valid;
    logic                hit;
    logic                swept;
    logic [COUNT_W-1:0]  evicted_count;
    logic [COUNT_W-1:0]  resident_count;
    logic                overflow;

    int                  outstanding;
    int                  fail_count;
    int                  cycles     = 0;
    int                  burst_left = 0;
    logic                hold_req   = 1'b0;

    // page pool for the current phase, first entries are the hot set
    logic [PW-1:0]       pool [128];
    int                  pool_n = 1;

    always #5 clk = ~clk;

    page_fault_frequency_tracker
    #(
        .TABLE_DEPTH (DEPTH),
        .PAGE_BITS   (PW)
    )
    i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .page_number    (page_number),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .swept          (swept),
        .evicted_count  (evicted_count),
        .resident_count (resident_count),
        .overflow       (overflow)
    );

    pft_checker
    #(
        .TABLE_DEPTH (DEPTH),
        .PAGE_BITS   (PW)
    )
    i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .page_number    (page_number),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .swept          (swept),
        .evicted_count  (evicted_count),
        .resident_count (resident_count),
        .overflow       (overflow),
        .outstanding    (outstanding),
        .fail_count     (fail_count)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: runs of varying stall density, plus one long hold-off
    initial
    begin
        int   stall_pct;
        int   run_left;
        int   k;
        logic hold_done;
        stall_pct = 0;
        run_left  = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                for (k = 0; k < HOLD_CYCLES; k++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            if (run_left == 0)
            begin
                run_left = $urandom_range(20, 120);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 90;
                endcase
            end
            run_left--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // offer one request and wait until it is taken; gaps fall between bursts
    task automatic send_page(input logic [PW-1:0] pg);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid    <= 1'b1;
        page_number <= pg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
    endtask

    // drain the block, then write the fault window
    task automatic set_window(input logic [WINDOW_W-1:0] w);
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly hot pages, some from the wider pool, a few fresh ones
    function automatic logic [PW-1:0] pick_page();
        int r;
        int hot;
        r   = $urandom_range(0, 99);
        hot = (pool_n < 8) ? pool_n : 8;
        if (r < 15)
            return PW'($urandom);
        if (r < 60)
            return pool[$urandom_range(0, hot - 1)];
        return pool[$urandom_range(0, pool_n - 1)];
    endfunction

    // stimulus and verdict
    initial
    begin
        logic [WINDOW_W-1:0] windows [NUM_PHASES];
        int                  ph;
        int                  k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window: first miss, hit, sweep with nothing evicted,
        // sweep that evicts, miss without a sweep
        send_page(20'h00000);
        send_page(20'h00000);
        send_page(20'hFFFFF);
        send_page(20'hFFFFF);
        send_page(20'h5A5A5);
        send_page(20'hA5A5A);

        // window of zero: every miss sweeps
        set_window(16'd0);
        send_page(20'h12345);
        send_page(20'h12345);
        send_page(20'h00001);
        send_page(20'h80000);
        send_page(20'h80000);
        send_page(20'h7FFFF);

        // random phases; the maximum window fills the table to overflow
        windows[0] = 16'hFFFF;
        windows[1] = 16'd1;
        windows[2] = 16'd0;
        windows[3] = 16'd3;
        windows[4] = WINDOW_W'($urandom_range(4, 64));
        windows[5] = 16'd2;
        windows[6] = WINDOW_W'($urandom);
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_window(windows[ph]);
            pool_n = (ph == 0) ? 90 : $urandom_range(4, 100);
            for (k = 0; k < pool_n; k++)
                pool[k] = PW'($urandom);
            if (ph == 0)
                hold_req <= 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
                send_page(pick_page());
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== page_fault_frequency_tracker.f =====
hdl/pft_pkg.sv
hdl/pft_ctrl.sv
hdl/pft_dp.sv
hdl/page_fault_frequency_tracker.sv
bench/pft_checker.sv
bench/tb.sv
